// ===== hw/rtl/imu_sfp_pkg.sv =====
// imu_sfp_pkg: constants, frame layout and scaling functions for the imu serial
// frame parser. Used by imu_serial_frame_parser, imu_frame_checker and the test; depends on nothing else.

package imu_sfp_pkg;

  // frame: sync byte, type byte, four little-endian words, checksum byte
  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned BUF_DEPTH = FRAME_LEN - 2;  // type and word bytes, checksum dropped
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
  localparam int unsigned BUF_IDX_W = $clog2(BUF_DEPTH);

  localparam logic [CNT_W-1:0] CNT_HUNT = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

  // byte positions inside the frame buffer
  localparam logic [BUF_IDX_W-1:0] POS_TYPE = BUF_IDX_W'(0);
  localparam logic [BUF_IDX_W-1:0] POS_X    = BUF_IDX_W'(1);
  localparam logic [BUF_IDX_W-1:0] POS_Y    = BUF_IDX_W'(3);
  localparam logic [BUF_IDX_W-1:0] POS_Z    = BUF_IDX_W'(5);
  localparam logic [BUF_IDX_W-1:0] POS_T    = BUF_IDX_W'(7);

  // frame type codes
  localparam logic [7:0] TYPE_ACC  = 8'h51;
  localparam logic [7:0] TYPE_GYRO = 8'h52;
  localparam logic [7:0] TYPE_ANG  = 8'h53;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_SYNC   = 1'b0;
  localparam logic [7:0]  SYNC_RESET = 8'h55;

  // raw*49/10240 == (raw*ACC_RECIP) >> ACC_SHIFT for |raw| <= 32768
  localparam logic [21:0] ACC_RECIP = 22'd2569012;
  localparam int unsigned ACC_SHIFT = 29;
  // raw*125/2048 is exact with a shift
  localparam logic [6:0]  GYRO_MUL   = 7'd125;
  localparam int unsigned GYRO_SHIFT = 11;
  // raw/100 == (raw*TEMP_RECIP) >> TEMP_SHIFT for |raw| <= 32768
  localparam logic [12:0] TEMP_RECIP = 13'd5243;
  localparam int unsigned TEMP_SHIFT = 19;

  typedef logic signed [15:0] word_t;
  typedef logic signed [11:0] scaled_t;
  typedef logic signed [9:0]  temp_t;

  function automatic logic [16:0] word_mag(input word_t w);
    logic [16:0] wext;
    wext = {w[15], w};
    return w[15] ? (~wext + 17'd1) : wext;
  endfunction

  // scale one axis word, truncated toward zero
  function automatic scaled_t scale_axis(input word_t w, input logic is_acc);
    logic [16:0] mag;
    logic [38:0] prod_acc;
    logic [23:0] prod_gyro;
    logic [10:0] q;
    logic [11:0] res;
    mag       = word_mag(w);
    prod_acc  = 39'(mag) * 39'(ACC_RECIP);
    prod_gyro = 24'(mag) * 24'(GYRO_MUL);
    if (is_acc) begin
      q = {1'b0, prod_acc[ACC_SHIFT +: 10]};
    end else begin
      q = prod_gyro[GYRO_SHIFT +: 11];
    end
    res = w[15] ? (12'd0 - {1'b0, q}) : {1'b0, q};
    return scaled_t'(res);
  endfunction

  function automatic temp_t temp_div(input word_t w);
    logic [16:0] mag;
    logic [29:0] prod;
    logic [8:0]  q;
    logic [9:0]  res;
    mag  = word_mag(w);
    prod = 30'(mag) * 30'(TEMP_RECIP);
    q    = prod[TEMP_SHIFT +: 9];
    res  = w[15] ? (10'd0 - {1'b0, q}) : {1'b0, q};
    return temp_t'(res);
  endfunction

endpackage

// ===== hw/rtl/imu_serial_frame_parser.sv =====
// imu_serial_frame_parser: sync hunt, frame assembly and scaling of imu frames.
// Depends on imu_sfp_pkg for frame layout, codes and scaling functions.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   input    | in        | in_valid_i / in_stall_o   | rx_byte_i
//   result   | out       | out_valid_o / out_stall_i | frame_type_o .. temperature_o
//   config   | in        | apb (psel .. pready)      | sync_byte at address 0
//
// one byte is taken per cycle unless in_stall_o is high; each byte passes through the input register.
// a result is loaded into the output registers when the checksum byte leaves the input register.
// reset clears the byte counter (hunting) and sets the sync byte to 0x55.
// out_stall_i only holds back the last byte of a frame while a result still waits;
// all other bytes keep flowing, so one result can wait while the next frame builds.

module imu_serial_frame_parser
  import imu_sfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            frame_type_o,
  output logic                  type_scaled_o,
  output logic signed [15:0]    word_x_o,
  output logic signed [15:0]    word_y_o,
  output logic signed [15:0]    word_z_o,
  output logic signed [15:0]    word_t_o,
  output logic signed [11:0]    scaled_x_o,
  output logic signed [11:0]    scaled_y_o,
  output logic signed [11:0]    scaled_z_o,
  output logic signed [9:0]     temperature_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                 in_vld_q, in_vld_d;
  logic [7:0]           in_byte_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [7:0]           buf_q [BUF_DEPTH];
  logic [BUF_IDX_W-1:0] wr_idx;
  logic [7:0]           sync_q;
  logic                 out_vld_q, out_vld_d;

  logic    accept, consume, is_last, out_free, emit, buf_we, cfg_we;
  logic    is_scaled, is_acc;
  logic [7:0] ftype;
  word_t   wx, wy, wz, wt;
  scaled_t sx, sy, sz;
  temp_t   tmp;

  logic [7:0]    frame_type_q;
  logic          type_scaled_q;
  word_t         word_x_q, word_y_q, word_z_q, word_t_q;
  scaled_t       scaled_x_q, scaled_y_q, scaled_z_q;
  temp_t         temperature_q;

  // handshake and byte counter
  assign is_last    = (cnt_q == CNT_LAST);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign consume    = in_vld_q && (!is_last || out_free);
  assign in_stall_o = in_vld_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;
  assign emit       = consume && is_last;
  assign buf_we     = consume && (cnt_q != CNT_HUNT) && !is_last;
  assign wr_idx     = BUF_IDX_W'(cnt_q - CNT_W'(1));

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (consume) begin
      in_vld_d = 1'b0;
    end

    cnt_d = cnt_q;
    if (consume) begin
      if (cnt_q == CNT_HUNT) begin
        cnt_d = (in_byte_q == sync_q) ? CNT_W'(1) : CNT_HUNT;
      end else if (is_last) begin
        cnt_d = CNT_HUNT;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end

    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      cnt_q     <= CNT_HUNT;
      out_vld_q <= 1'b0;
      sync_q    <= SYNC_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      if (cfg_we) begin
        sync_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
    // checksum byte is not kept
    if (buf_we) begin
      buf_q[wr_idx] <= in_byte_q;
    end
  end

  // frame decode and scaling
  assign ftype     = buf_q[POS_TYPE];
  assign is_acc    = (ftype == TYPE_ACC);
  assign is_scaled = is_acc || (ftype == TYPE_GYRO) || (ftype == TYPE_ANG);
  assign wx = word_t'({buf_q[POS_X + BUF_IDX_W'(1)], buf_q[POS_X]});
  assign wy = word_t'({buf_q[POS_Y + BUF_IDX_W'(1)], buf_q[POS_Y]});
  assign wz = word_t'({buf_q[POS_Z + BUF_IDX_W'(1)], buf_q[POS_Z]});
  assign wt = word_t'({buf_q[POS_T + BUF_IDX_W'(1)], buf_q[POS_T]});
  assign sx  = scale_axis(wx, is_acc);
  assign sy  = scale_axis(wy, is_acc);
  assign sz  = scale_axis(wz, is_acc);
  assign tmp = temp_div(wt);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_type_q  <= ftype;
      type_scaled_q <= is_scaled;
      word_x_q      <= wx;
      word_y_q      <= wy;
      word_z_q      <= wz;
      word_t_q      <= wt;
      scaled_x_q    <= is_scaled ? sx  : '0;
      scaled_y_q    <= is_scaled ? sy  : '0;
      scaled_z_q    <= is_scaled ? sz  : '0;
      temperature_q <= is_scaled ? tmp : '0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign frame_type_o  = frame_type_q;
  assign type_scaled_o = type_scaled_q;
  assign word_x_o      = word_x_q;
  assign word_y_o      = word_y_q;
  assign word_z_o      = word_z_q;
  assign word_t_o      = word_t_q;
  assign scaled_x_o    = scaled_x_q;
  assign scaled_y_o    = scaled_y_q;
  assign scaled_z_o    = scaled_z_q;
  assign temperature_o = temperature_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SYNC);
  assign prdata = (paddr[2] == REG_SYNC) ? CFG_DATA_W'(sync_q) : '0;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LAST)
    else $error("byte counter beyond frame length");

  a_unscaled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !type_scaled_o |->
      scaled_x_o == '0 && scaled_y_o == '0 && scaled_z_o == '0 && temperature_o == '0)
    else $error("scaled fields nonzero for unknown frame type");

  a_scaled_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> type_scaled_o ==
      (frame_type_o == TYPE_ACC || frame_type_o == TYPE_GYRO || frame_type_o == TYPE_ANG))
    else $error("type_scaled does not match frame type");

  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      scaled_x_o >= -12'sd2000 && scaled_x_o <= 12'sd2000 &&
      scaled_y_o >= -12'sd2000 && scaled_y_o <= 12'sd2000 &&
      scaled_z_o >= -12'sd2000 && scaled_z_o <= 12'sd2000 &&
      temperature_o >= -10'sd328 && temperature_o <= 10'sd328)
    else $error("scaled value out of range");

  a_emit_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cnt_q) == CNT_LAST)
    else $error("result loaded without a complete frame");
`endif

endmodule

// ===== tb/imu_frame_checker.sv =====
// imu_frame_checker: watches the byte, result and apb channels of the imu serial frame
// parser, rebuilds each frame from the accepted bytes and compares every result.
// Depends on imu_sfp_pkg for field types, frame length, type codes and the sync reset.

module imu_frame_checker
  import imu_sfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,

  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [7:0]            frame_type_o,
  input  logic                  type_scaled_o,
  input  logic signed [15:0]    word_x_o,
  input  logic signed [15:0]    word_y_o,
  input  logic signed [15:0]    word_z_o,
  input  logic signed [15:0]    word_t_o,
  input  logic signed [11:0]    scaled_x_o,
  input  logic signed [11:0]    scaled_y_o,
  input  logic signed [11:0]    scaled_z_o,
  input  logic signed [9:0]     temperature_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,

  output int unsigned           mismatches,
  output int unsigned           pending,
  output int unsigned           frames_checked
);

  typedef struct {
    logic [7:0] kind;
    logic       scaled;
    word_t      wx;
    word_t      wy;
    word_t      wz;
    word_t      wt;
    scaled_t    sx;
    scaled_t    sy;
    scaled_t    sz;
    temp_t      temp;
  } frame_rec_t;

  frame_rec_t  frames_due[$];
  logic [7:0]  sync_q = SYNC_RESET;
  logic [7:0]  held[FRAME_LEN-1];
  int unsigned fill = 0;

  initial begin
    mismatches     = 0;
    pending        = 0;
    frames_checked = 0;
  end

  // 156.8/32768 reduces to 49/10240, 2000/32768 to 125/2048; int division truncates to zero
  function automatic scaled_t axis_scaled(input word_t w, input logic [7:0] kind);
    int raw;
    raw = w;
    if (kind == TYPE_ACC) return scaled_t'((raw * 49) / 10240);
    return scaled_t'((raw * 125) / 2048);
  endfunction

  function automatic word_t word_from(input int unsigned lo);
    return word_t'({held[lo+1], held[lo]});
  endfunction

  task automatic take_byte(input logic [7:0] b);
    frame_rec_t f;
    int         raw_t;
    if (fill == 0) begin
      fill = (b == sync_q) ? 1 : 0;
      return;
    end
    held[fill-1] = b;
    fill++;
    if (fill < FRAME_LEN) return;
    fill     = 0;
    f.kind   = held[0];
    f.scaled = (f.kind == TYPE_ACC) || (f.kind == TYPE_GYRO) || (f.kind == TYPE_ANG);
    f.wx     = word_from(1);
    f.wy     = word_from(3);
    f.wz     = word_from(5);
    f.wt     = word_from(7);
    raw_t    = f.wt;
    f.sx     = f.scaled ? axis_scaled(f.wx, f.kind) : '0;
    f.sy     = f.scaled ? axis_scaled(f.wy, f.kind) : '0;
    f.sz     = f.scaled ? axis_scaled(f.wz, f.kind) : '0;
    f.temp   = f.scaled ? temp_t'(raw_t / 100) : '0;
    frames_due = {frames_due, f};
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d %s: expected %0d, got %0d", frames_checked, what, want, got);
  endtask

  always @(posedge clk_i) begin : watch
    frame_rec_t want;
    if (!rst_ni) begin
      sync_q = SYNC_RESET;
      fill   = 0;
      frames_due.delete();
    end else begin
      if (psel && penable && pready && ((paddr >> 2) == REG_SYNC)) begin
        if (pwrite) begin
          sync_q = pwdata[7:0];
        end else if (prdata[7:0] !== sync_q) begin
          note_mismatch("sync_byte readback", sync_q, prdata[7:0]);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          note_mismatch("transaction with no frame due, frame_type", -1, frame_type_o);
        end else begin
          want = frames_due.pop_front();
          if (frame_type_o !== want.kind)   note_mismatch("frame_type", want.kind, frame_type_o);
          if (type_scaled_o !== want.scaled)
            note_mismatch("type_scaled", want.scaled, type_scaled_o);
          if (word_x_o !== want.wx)         note_mismatch("word_x", want.wx, word_x_o);
          if (word_y_o !== want.wy)         note_mismatch("word_y", want.wy, word_y_o);
          if (word_z_o !== want.wz)         note_mismatch("word_z", want.wz, word_z_o);
          if (word_t_o !== want.wt)         note_mismatch("word_t", want.wt, word_t_o);
          if (scaled_x_o !== want.sx)       note_mismatch("scaled_x", want.sx, scaled_x_o);
          if (scaled_y_o !== want.sy)       note_mismatch("scaled_y", want.sy, scaled_y_o);
          if (scaled_z_o !== want.sz)       note_mismatch("scaled_z", want.sz, scaled_z_o);
          if (temperature_o !== want.temp)
            note_mismatch("temperature", want.temp, temperature_o);
          frames_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) take_byte(rx_byte_i);
    end
    pending = frames_due.size();
  end

endmodule

// ===== tb/imu_serial_frame_parser_test.sv =====
// imu_serial_frame_parser_test: drives bytes, apb writes and result stalls into the
// imu serial frame parser and gives the verdict from imu_frame_checker's counts.
// Depends on imu_sfp_pkg, imu_serial_frame_parser and imu_frame_checker.

module imu_serial_frame_parser_test;
  import imu_sfp_pkg::*;

  localparam int unsigned GAP_MAX      = 8;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned FRAMES_PHASE = 7;
  localparam int unsigned REG_SPARE    = 1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SYNC  = CFG_ADDR_W'(4 * REG_SYNC);
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = CFG_ADDR_W'(4 * REG_SPARE);

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [7:0]            rx_byte_i   = 8'h00;
  logic                  out_stall_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [CFG_DATA_W-1:0] pwdata      = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [7:0]            frame_type_o;
  logic                  type_scaled_o;
  logic signed [15:0]    word_x_o, word_y_o, word_z_o, word_t_o;
  logic signed [11:0]    scaled_x_o, scaled_y_o, scaled_z_o;
  logic signed [9:0]     temperature_o;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches, pending, frames_checked;
  int unsigned cycles      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned frames_sent = 0;
  int unsigned settings    = 1;
  logic [7:0]  sync_now    = SYNC_RESET;
  bit          calm        = 1'b0;

  imu_serial_frame_parser uut (.*);

  imu_frame_checker frame_check (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[imu_serial_frame_parser] ERROR");
      $finish;
    end
  end

  // result side: after each transaction hold stall for a random number of cycles
  always @(posedge clk_i) begin : sink_pacing
    int unsigned hold, g;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        g           = calm ? 0 : $urandom_range(0, GAP_MAX);
        hold        = g;
        out_stall_i <= (g != 0);
      end else if (hold > 1) begin
        hold = hold - 1;
      end else begin
        hold        = 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] kind, input word_t x, input word_t y,
                            input word_t z, input word_t t, input logic [7:0] csum);
    send_byte(sync_now);
    send_byte(kind);
    send_byte(x[7:0]); send_byte(x[15:8]);
    send_byte(y[7:0]); send_byte(y[15:8]);
    send_byte(z[7:0]); send_byte(z[15:8]);
    send_byte(t[7:0]); send_byte(t[15:8]);
    send_byte(csum);
    frames_sent++;
  endtask

  // wait until every frame due has come out and the input register has emptied
  task automatic settle_out();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic change_sync(input logic [7:0] v);
    settle_out();
    apb_access(1'b1, ADDR_SYNC, {16'($urandom_range(0, 16'hffff)), 8'h00, v});
    apb_access(1'b0, ADDR_SYNC, '0);
    sync_now = v;
    settings++;
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return word_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 5))
      0:       return TYPE_ACC;
      1:       return TYPE_GYRO;
      2:       return TYPE_ANG;
      3:       return sync_now;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_frames(input int unsigned n);
    int unsigned k;
    repeat (n) begin
      calm <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        2: begin
          // cut-short frame: a sync and a few bytes, so the next frame lands mid-frame
          send_byte(sync_now);
          k = $urandom_range(1, 9);
          repeat (k) send_byte(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_frame(pick_kind(), pick_word(), pick_word(), pick_word(), pick_word(),
                 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) settle_out();
    end
  endtask

  initial begin : stimulus
    int unsigned tail;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: dropped byte while hunting, extreme words, sync value inside a frame
    calm <= 1'b1;
    send_byte(8'haa);
    send_frame(TYPE_ACC, 16'h8000, 16'h7fff, 16'hffff, 16'h8000, 8'h00);
    calm <= 1'b0;
    send_frame(TYPE_GYRO, 16'h5555, 16'h7fff, 16'h8000, 16'h7fff, SYNC_RESET);

    settle_out();
    // a write past the last register must leave the sync byte alone
    apb_access(1'b1, ADDR_SPARE, 32'hffff_ffff);
    apb_access(1'b0, ADDR_SYNC, '0);

    random_frames(FRAMES_PHASE);
    change_sync(8'h00);
    random_frames(FRAMES_PHASE);
    change_sync(8'hff);
    random_frames(FRAMES_PHASE);
    change_sync(TYPE_ACC);
    random_frames(FRAMES_PHASE);
    change_sync(8'($urandom_range(0, 255)));
    random_frames(FRAMES_PHASE);
    change_sync(SYNC_RESET);
    random_frames(FRAMES_PHASE);

    in_valid_i <= 1'b0;
    tail = 0;
    while (pending != 0 && tail < DRAIN_LIMIT) begin
      @(negedge clk_i);
      tail++;
    end
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);

    $display("sent %0d bytes holding %0d framed sequences under %0d sync settings",
             bytes_sent, frames_sent, settings);
    $display("checked %0d results, %0d mismatches, %0d still due",
             frames_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[imu_serial_frame_parser] OK");
    end else begin
      $display("[imu_serial_frame_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/imu_sfp_pkg.sv
hw/rtl/imu_serial_frame_parser.sv
tb/imu_frame_checker.sv
tb/imu_serial_frame_parser_test.sv
